[src/assert_macros.svh]
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands, clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define AST_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define AST_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[src/gpsa_pkg.sv]
// ---------------------------------------------------------------------------
// gpsa_pkg
// Beat types, codes and saturation helpers of the stiffness accumulator.
// ---------------------------------------------------------------------------
package gpsa_pkg;

  typedef enum logic [1:0] {
    ACT_LOAD     = 2'd0,
    ACT_RD_STIFF = 2'd1,
    ACT_RD_FORCE = 2'd2,
    ACT_CLEAR    = 2'd3
  } act_t;

  typedef struct packed {
    act_t               action;
    logic signed [31:0] grad_x;
    logic signed [31:0] grad_y;
    logic signed [31:0] weight;
    logic signed [31:0] flux_x;
    logic signed [31:0] flux_y;
    logic [3:0]         row_index;
    logic [3:0]         col_index;
  } in_item_t;

  typedef struct packed {
    logic signed [47:0] entry_value;
    logic               overflow;
  } out_item_t;

  localparam logic [2:0] CFG_D_XX = 3'd0;
  localparam logic [2:0] CFG_D_XY = 3'd1;
  localparam logic [2:0] CFG_D_YX = 3'd2;
  localparam logic [2:0] CFG_D_YY = 3'd3;
  localparam logic [2:0] CFG_DOF  = 3'd4;

  // Multiplier operand pairs.
  typedef enum logic [3:0] {
    MS_FX_W, MS_FY_W, MS_X_W, MS_Y_W,
    MS_DXX_WB0, MS_DXY_WB1, MS_DYX_WB0, MS_DYY_WB1,
    MS_X_DB0, MS_Y_DB1, MS_X_HF0, MS_Y_HF1
  } mul_sel_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_HF0, OP_HF1, OP_WB0, OP_WB1, OP_ACC_LD,
    OP_DB0, OP_DB1, OP_S_WR, OP_F_WR, OP_CLR, OP_OUT
  } dp_op_t;

  typedef enum logic [1:0] {
    AS_J, AS_I, AS_READ, AS_SWEEP
  } addr_sel_t;

  typedef struct packed {
    logic      cap_item;
    logic      col_we;
    mul_sel_t  mul_sel;
    dp_op_t    op;
    addr_sel_t addr_sel;
  } cmd_t;

  typedef struct packed {
    logic final_col;
    logic i_last;
    logic j_last;
  } sts_t;

  localparam logic signed [48:0] S32_MAX = 49'sd2147483647;
  localparam logic signed [48:0] S32_MIN = -S32_MAX - 49'sd1;
  localparam logic signed [49:0] S48_MAX = 50'sd140737488355327;
  localparam logic signed [49:0] S48_MIN = -S48_MAX - 50'sd1;

  // {clamped, value}
  function automatic logic [32:0] sat32(input logic signed [48:0] x);
    if (x > S32_MAX) return {1'b1, 32'h7FFF_FFFF};
    if (x < S32_MIN) return {1'b1, 32'h8000_0000};
    return {1'b0, x[31:0]};
  endfunction

  function automatic logic [48:0] sat48(input logic signed [49:0] x);
    if (x > S48_MAX) return {1'b1, 48'h7FFF_FFFF_FFFF};
    if (x < S48_MIN) return {1'b1, 48'h8000_0000_0000};
    return {1'b0, x[47:0]};
  endfunction

endpackage

[src/gpsa_ram.sv]
// ---------------------------------------------------------------------------
// gpsa_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ---------------------------------------------------------------------------
module gpsa_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[src/gpsa_ctrl.sv]
// ---------------------------------------------------------------------------
// gpsa_ctrl
// Sequencer: item decode, accumulation loops, clearing sweep, result slot.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module gpsa_ctrl #(
  parameter int MAX_DOF = 16,
  localparam int IW = $clog2(MAX_DOF),
  localparam int AW = $clog2(MAX_DOF * MAX_DOF)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  gpsa_pkg::act_t    in_action,
  output logic              busy,
  input  logic              out_stall,
  output logic              out_valid,
  input  gpsa_pkg::sts_t    sts,
  output gpsa_pkg::cmd_t    cmd,
  output logic [IW-1:0]     cnt,
  output logic [IW-1:0]     idx_i,
  output logic [IW-1:0]     idx_j,
  output logic [AW-1:0]     sweep
);

  localparam logic [AW-1:0] SWEEP_LAST = AW'(MAX_DOF * MAX_DOF - 1);

  typedef enum logic [4:0] {
    S_CLR, S_IDLE, S_HF0, S_HF1, S_HF2,
    S_J0, S_J1, S_J2, S_J3, S_J4, S_J5, S_J6, S_J7,
    S_I0, S_I1, S_I2, S_I3,
    S_F0, S_F1, S_F2, S_F3,
    S_RD0, S_RD1
  } state_t;

  state_t        state_r, state_nxt;
  logic [IW-1:0] cnt_r, cnt_nxt, i_r, i_nxt, j_r, j_nxt;
  logic [AW-1:0] sweep_r, sweep_nxt;
  logic          out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    sweep_nxt     = sweep_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd = '{cap_item: 1'b0, col_we: 1'b0, mul_sel: gpsa_pkg::MS_X_W,
            op: gpsa_pkg::OP_NONE, addr_sel: gpsa_pkg::AS_I};
    unique case (state_r)
      S_CLR: begin
        cmd.op       = gpsa_pkg::OP_CLR;
        cmd.addr_sel = gpsa_pkg::AS_SWEEP;
        sweep_nxt    = sweep_r + AW'(1);
        if (sweep_r == SWEEP_LAST) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.cap_item = 1'b1;
          unique case (in_action)
            gpsa_pkg::ACT_LOAD: begin
              cmd.col_we = 1'b1;
              if (sts.final_col) state_nxt = S_HF0;
              else cnt_nxt = cnt_r + IW'(1);
            end
            gpsa_pkg::ACT_RD_STIFF, gpsa_pkg::ACT_RD_FORCE: state_nxt = S_RD0;
            gpsa_pkg::ACT_CLEAR: begin
              cnt_nxt   = '0;
              sweep_nxt = '0;
              state_nxt = S_CLR;
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_HF0: begin
        cmd.mul_sel = gpsa_pkg::MS_FX_W;
        state_nxt   = S_HF1;
      end
      S_HF1: begin
        cmd.op      = gpsa_pkg::OP_HF0;
        cmd.mul_sel = gpsa_pkg::MS_FY_W;
        state_nxt   = S_HF2;
      end
      S_HF2: begin
        cmd.op    = gpsa_pkg::OP_HF1;
        j_nxt     = '0;
        state_nxt = S_J0;
      end
      S_J0: begin
        cmd.addr_sel = gpsa_pkg::AS_J;
        state_nxt    = S_J1;
      end
      S_J1: begin
        cmd.addr_sel = gpsa_pkg::AS_J;
        cmd.mul_sel  = gpsa_pkg::MS_X_W;
        state_nxt    = S_J2;
      end
      S_J2: begin
        cmd.addr_sel = gpsa_pkg::AS_J;
        cmd.op       = gpsa_pkg::OP_WB0;
        cmd.mul_sel  = gpsa_pkg::MS_Y_W;
        state_nxt    = S_J3;
      end
      S_J3: begin
        cmd.op      = gpsa_pkg::OP_WB1;
        cmd.mul_sel = gpsa_pkg::MS_DXX_WB0;
        state_nxt   = S_J4;
      end
      S_J4: begin
        cmd.op      = gpsa_pkg::OP_ACC_LD;
        cmd.mul_sel = gpsa_pkg::MS_DXY_WB1;
        state_nxt   = S_J5;
      end
      S_J5: begin
        cmd.op      = gpsa_pkg::OP_DB0;
        cmd.mul_sel = gpsa_pkg::MS_DYX_WB0;
        state_nxt   = S_J6;
      end
      S_J6: begin
        cmd.op      = gpsa_pkg::OP_ACC_LD;
        cmd.mul_sel = gpsa_pkg::MS_DYY_WB1;
        state_nxt   = S_J7;
      end
      S_J7: begin
        cmd.op    = gpsa_pkg::OP_DB1;
        i_nxt     = '0;
        state_nxt = S_I0;
      end
      S_I0: state_nxt = S_I1;
      S_I1: begin
        cmd.mul_sel = gpsa_pkg::MS_X_DB0;
        state_nxt   = S_I2;
      end
      S_I2: begin
        cmd.op      = gpsa_pkg::OP_ACC_LD;
        cmd.mul_sel = gpsa_pkg::MS_Y_DB1;
        state_nxt   = S_I3;
      end
      S_I3: begin
        cmd.op = gpsa_pkg::OP_S_WR;
        if (!sts.i_last) begin
          i_nxt     = i_r + IW'(1);
          state_nxt = S_I0;
        end else if (!sts.j_last) begin
          j_nxt     = j_r + IW'(1);
          state_nxt = S_J0;
        end else begin
          i_nxt     = '0;
          state_nxt = S_F0;
        end
      end
      S_F0: state_nxt = S_F1;
      S_F1: begin
        cmd.mul_sel = gpsa_pkg::MS_X_HF0;
        state_nxt   = S_F2;
      end
      S_F2: begin
        cmd.op      = gpsa_pkg::OP_ACC_LD;
        cmd.mul_sel = gpsa_pkg::MS_Y_HF1;
        state_nxt   = S_F3;
      end
      S_F3: begin
        cmd.op = gpsa_pkg::OP_F_WR;
        if (sts.i_last) begin
          cnt_nxt   = '0;
          state_nxt = S_IDLE;
        end else begin
          i_nxt     = i_r + IW'(1);
          state_nxt = S_F0;
        end
      end
      S_RD0: begin
        cmd.addr_sel = gpsa_pkg::AS_READ;
        state_nxt    = S_RD1;
      end
      S_RD1: begin
        cmd.addr_sel = gpsa_pkg::AS_READ;
        // hold the read until the result slot frees up
        if (!out_valid_r || !out_stall) begin
          cmd.op        = gpsa_pkg::OP_OUT;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      cnt_r       <= '0;
      i_r         <= '0;
      j_r         <= '0;
      sweep_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      sweep_r     <= sweep_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign cnt       = cnt_r;
  assign idx_i     = i_r;
  assign idx_j     = j_r;
  assign sweep     = sweep_r;

  `AST_NXT(a_result_held, out_valid_r && out_stall, out_valid_r, "waiting result dropped")
  `AST_IMP(a_no_overwrite, out_valid_r && out_stall, cmd.op != gpsa_pkg::OP_OUT, "result overwritten")
  `AST_NXT(a_force_after_stiff, state_r == S_I3 && sts.i_last && sts.j_last, state_r == S_F0, "force pass skipped")

endmodule

[src/gpsa_datapath.sv]
// ---------------------------------------------------------------------------
// gpsa_datapath
// Configuration, stores, shared multiplier, saturating accumulate, result.
// ---------------------------------------------------------------------------
module gpsa_datapath #(
  parameter int MAX_DOF = 16,
  localparam int IW = $clog2(MAX_DOF),
  localparam int AW = $clog2(MAX_DOF * MAX_DOF)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [31:0]         cfg_data,
  input  gpsa_pkg::in_item_t  item,
  input  gpsa_pkg::cmd_t      cmd,
  output gpsa_pkg::sts_t      sts,
  input  logic [IW-1:0]       cnt,
  input  logic [IW-1:0]       idx_i,
  input  logic [IW-1:0]       idx_j,
  input  logic [AW-1:0]       sweep,
  output gpsa_pkg::out_item_t result
);

  logic signed [31:0] d_xx_r, d_xy_r, d_yx_r, d_yy_r;
  logic [4:0]         dof_r;
  logic [IW-1:0]      nm1;

  logic signed [31:0] w_r, fx_r, fy_r, hf0_r, hf1_r, wb0_r, wb1_r, db0_r, db1_r;
  logic signed [47:0] acc_r;
  logic signed [63:0] p_r;
  logic [IW-1:0]      rd_row_r, rd_col_r;
  logic               rd_oob_r, rd_force_r, ovf_r, ovf_nxt;
  gpsa_pkg::out_item_t out_r;

  logic signed [31:0] col_x, col_y, ma, mb;
  logic [47:0]        s_rdata, f_rdata, s_wdata;
  logic [AW-1:0]      s_addr;
  logic [IW-1:0]      f_addr, f_waddr, c_raddr, c_waddr;
  logic               s_we, f_we;
  logic signed [47:0] flp, rd_sel;
  logic [32:0]        sat_a, sat_b;
  logic [48:0]        sat_c;
  logic signed [49:0] sum50;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_xx_r <= 32'sd65536;
      d_xy_r <= '0;
      d_yx_r <= '0;
      d_yy_r <= 32'sd65536;
      dof_r  <= 5'd4;
    end else if (cfg_we) begin
      unique case (cfg_index)
        gpsa_pkg::CFG_D_XX: d_xx_r <= cfg_data;
        gpsa_pkg::CFG_D_XY: d_xy_r <= cfg_data;
        gpsa_pkg::CFG_D_YX: d_yx_r <= cfg_data;
        gpsa_pkg::CFG_D_YY: d_yy_r <= cfg_data;
        gpsa_pkg::CFG_DOF:  dof_r  <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // clamp dof_count to 1..MAX_DOF, keep n-1
  always_comb begin
    if (dof_r == 5'd0) nm1 = '0;
    else if (7'(dof_r) > 7'(MAX_DOF)) nm1 = IW'(MAX_DOF - 1);
    else nm1 = IW'(dof_r - 5'd1);
  end

  assign sts.final_col = (cnt >= nm1);
  assign sts.i_last    = (idx_i == nm1);
  assign sts.j_last    = (idx_j == nm1);

  // column stores
  assign c_waddr = sts.final_col ? nm1 : cnt;
  assign c_raddr = (cmd.addr_sel == gpsa_pkg::AS_J) ? idx_j : idx_i;

  gpsa_ram #(.WIDTH(32), .DEPTH(MAX_DOF)) u_col_x (
    .clk(clk), .we(cmd.col_we), .waddr(c_waddr), .wdata(item.grad_x),
    .raddr(c_raddr), .rdata(col_x)
  );

  gpsa_ram #(.WIDTH(32), .DEPTH(MAX_DOF)) u_col_y (
    .clk(clk), .we(cmd.col_we), .waddr(c_waddr), .wdata(item.grad_y),
    .raddr(c_raddr), .rdata(col_y)
  );

  always_comb begin
    case (cmd.addr_sel)
      gpsa_pkg::AS_READ: begin
        s_addr = AW'(AW'(rd_row_r) * AW'(MAX_DOF) + AW'(rd_col_r));
        f_addr = rd_row_r;
      end
      gpsa_pkg::AS_SWEEP: begin
        s_addr = sweep;
        f_addr = IW'(sweep);
      end
      default: begin
        s_addr = AW'(AW'(idx_i) * AW'(MAX_DOF) + AW'(idx_j));
        f_addr = idx_i;
      end
    endcase
  end

  assign flp    = p_r[63:16];
  assign rd_sel = (cmd.op == gpsa_pkg::OP_F_WR) ? f_rdata : s_rdata;
  assign sat_a  = gpsa_pkg::sat32({flp[47], flp});
  assign sat_b  = gpsa_pkg::sat32({acc_r[47], acc_r} + {flp[47], flp});
  assign sum50  = {{2{rd_sel[47]}}, rd_sel} + {{2{acc_r[47]}}, acc_r}
                + {{2{flp[47]}}, flp};
  assign sat_c  = gpsa_pkg::sat48(sum50);

  assign s_we    = (cmd.op == gpsa_pkg::OP_S_WR) || (cmd.op == gpsa_pkg::OP_CLR);
  assign f_we    = (cmd.op == gpsa_pkg::OP_F_WR) ||
                   ((cmd.op == gpsa_pkg::OP_CLR) && (sweep < AW'(MAX_DOF)));
  assign s_wdata = (cmd.op == gpsa_pkg::OP_CLR) ? 48'd0 : sat_c[47:0];
  assign f_waddr = f_addr;

  gpsa_ram #(.WIDTH(48), .DEPTH(MAX_DOF * MAX_DOF)) u_stiff (
    .clk(clk), .we(s_we), .waddr(s_addr), .wdata(s_wdata),
    .raddr(s_addr), .rdata(s_rdata)
  );

  gpsa_ram #(.WIDTH(48), .DEPTH(MAX_DOF)) u_force (
    .clk(clk), .we(f_we), .waddr(f_waddr), .wdata(s_wdata),
    .raddr(f_addr), .rdata(f_rdata)
  );

  always_comb begin
    case (cmd.mul_sel)
      gpsa_pkg::MS_FX_W:    begin ma = fx_r;   mb = w_r;   end
      gpsa_pkg::MS_FY_W:    begin ma = fy_r;   mb = w_r;   end
      gpsa_pkg::MS_X_W:     begin ma = col_x;  mb = w_r;   end
      gpsa_pkg::MS_Y_W:     begin ma = col_y;  mb = w_r;   end
      gpsa_pkg::MS_DXX_WB0: begin ma = d_xx_r; mb = wb0_r; end
      gpsa_pkg::MS_DXY_WB1: begin ma = d_xy_r; mb = wb1_r; end
      gpsa_pkg::MS_DYX_WB0: begin ma = d_yx_r; mb = wb0_r; end
      gpsa_pkg::MS_DYY_WB1: begin ma = d_yy_r; mb = wb1_r; end
      gpsa_pkg::MS_X_DB0:   begin ma = col_x;  mb = db0_r; end
      gpsa_pkg::MS_Y_DB1:   begin ma = col_y;  mb = db1_r; end
      gpsa_pkg::MS_X_HF0:   begin ma = col_x;  mb = hf0_r; end
      gpsa_pkg::MS_Y_HF1:   begin ma = col_y;  mb = hf1_r; end
      default:              begin ma = col_x;  mb = w_r;   end
    endcase
  end

  always_comb begin
    ovf_nxt = ovf_r;
    case (cmd.op)
      gpsa_pkg::OP_HF0, gpsa_pkg::OP_HF1,
      gpsa_pkg::OP_WB0, gpsa_pkg::OP_WB1: ovf_nxt = ovf_r | sat_a[32];
      gpsa_pkg::OP_DB0, gpsa_pkg::OP_DB1: ovf_nxt = ovf_r | sat_b[32];
      gpsa_pkg::OP_S_WR, gpsa_pkg::OP_F_WR: ovf_nxt = ovf_r | sat_c[48];
      gpsa_pkg::OP_CLR: ovf_nxt = 1'b0;
      default: ovf_nxt = ovf_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovf_r <= 1'b0;
    end else begin
      ovf_r <= ovf_nxt;
    end
  end

  always_ff @(posedge clk) begin
    p_r <= ma * mb;
    if (cmd.cap_item) begin
      w_r        <= item.weight;
      fx_r       <= item.flux_x;
      fy_r       <= item.flux_y;
      rd_row_r   <= IW'(item.row_index);
      rd_col_r   <= IW'(item.col_index);
      rd_force_r <= (item.action == gpsa_pkg::ACT_RD_FORCE);
      rd_oob_r   <= (6'(item.row_index) >= 6'(MAX_DOF)) ||
                    ((item.action == gpsa_pkg::ACT_RD_STIFF) &&
                     (6'(item.col_index) >= 6'(MAX_DOF)));
    end
    case (cmd.op)
      gpsa_pkg::OP_HF0:    hf0_r <= sat_a[31:0];
      gpsa_pkg::OP_HF1:    hf1_r <= sat_a[31:0];
      gpsa_pkg::OP_WB0:    wb0_r <= sat_a[31:0];
      gpsa_pkg::OP_WB1:    wb1_r <= sat_a[31:0];
      gpsa_pkg::OP_ACC_LD: acc_r <= flp;
      gpsa_pkg::OP_DB0:    db0_r <= sat_b[31:0];
      gpsa_pkg::OP_DB1:    db1_r <= sat_b[31:0];
      gpsa_pkg::OP_OUT: begin
        out_r.entry_value <= rd_oob_r ? 48'sd0 : (rd_force_r ? f_rdata : s_rdata);
        out_r.overflow    <= ovf_r;
      end
      default: ;
    endcase
  end

  assign result = out_r;

endmodule

[src/gauss_point_stiffness_accumulator.sv]
// ---------------------------------------------------------------------------
// gauss_point_stiffness_accumulator
// Accumulates weight*B^T*D*B and B^T*flux*weight per integration point.
// ---------------------------------------------------------------------------
// A non-final column load leaves the block idle. The final column starts the
// accumulation on one shared 32x32 multiplier, one product per cycle, each
// stiffness entry a read-modify-write of the stiffness RAM. A read passes
// through states RD0 and RD1, and the next beat is taken while a result
// waits on out_stall. After reset and on a clear the stiffness and force
// stores are swept to zero, during which no beat is taken; config writes
// are always taken.
module gauss_point_stiffness_accumulator #(
  parameter int MAX_DOF = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  gpsa_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output gpsa_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [2:0]          cfg_index,
  input  logic [31:0]         cfg_data
);

  localparam int IW = $clog2(MAX_DOF);
  localparam int AW = $clog2(MAX_DOF * MAX_DOF);

  gpsa_pkg::cmd_t cmd;
  gpsa_pkg::sts_t sts;
  logic [IW-1:0]  cnt, idx_i, idx_j;
  logic [AW-1:0]  sweep;

  assign cfg_ready = 1'b1;

  gpsa_ctrl #(.MAX_DOF(MAX_DOF)) u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_action(in_data.action),
    .busy(in_stall), .out_stall(out_stall), .out_valid(out_valid),
    .sts(sts), .cmd(cmd), .cnt(cnt), .idx_i(idx_i), .idx_j(idx_j), .sweep(sweep)
  );

  gpsa_datapath #(.MAX_DOF(MAX_DOF)) u_dp (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_valid && cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data), .item(in_data),
    .cmd(cmd), .sts(sts), .cnt(cnt), .idx_i(idx_i), .idx_j(idx_j),
    .sweep(sweep), .result(out_data)
  );

endmodule
